// ===== rtl/core/bdm_pkg.sv =====
// ----------------------------------------------------------------------------
// BCD digit multiplier package
// Widths, digit and column types shared by the multiplier core and channels.
// ----------------------------------------------------------------------------
package bdm_pkg;

  localparam int MaxDigits     = 8;
  localparam int DigitWidth    = 4;
  localparam int OperandWidth  = MaxDigits * DigitWidth;
  localparam int ProductDigits = 2 * MaxDigits;
  localparam int ProductWidth  = ProductDigits * DigitWidth;
  localparam int CfgWidth      = 4;
  // worst column: MaxDigits products of two 15-valued nibbles
  localparam int ColWidth      = $clog2(MaxDigits * 225 + 1);

  localparam logic [CfgWidth-1:0] CfgDigitsReset = CfgWidth'(MaxDigits);
  localparam logic [ColWidth-1:0] ColMaxValid    = ColWidth'(MaxDigits * 81);
  localparam logic [DigitWidth-1:0] DigitMaxSum  = DigitWidth'(11);

  typedef logic [DigitWidth-1:0]              bcd_digit_t;
  typedef bcd_digit_t [ProductDigits-1:0]     digit_vec_t;
  typedef logic [ColWidth-1:0]                col_sum_t;
  typedef col_sum_t [ProductDigits-1:0]       col_vec_t;

endpackage

// ===== rtl/core/bdm_operand_if.sv =====
// ----------------------------------------------------------------------------
// BCD multiplier operand channel
// Valid/ready channel carrying one pair of packed-BCD operands.
// ----------------------------------------------------------------------------
interface bdm_operand_if import bdm_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [OperandWidth-1:0] multiplicand_bcd;
  logic [OperandWidth-1:0] multiplier_bcd;

  modport source (output valid, output multiplicand_bcd, output multiplier_bcd,
                  input ready);
  modport sink   (input valid, input multiplicand_bcd, input multiplier_bcd,
                  output ready);

endinterface

// ===== rtl/core/bdm_product_if.sv =====
// ----------------------------------------------------------------------------
// BCD multiplier product channel
// Valid/ready channel carrying the packed-BCD product and the error flag.
// ----------------------------------------------------------------------------
interface bdm_product_if import bdm_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [ProductWidth-1:0] product_bcd;
  logic                    input_error;

  modport source (output valid, output product_bcd, output input_error,
                  input ready);
  modport sink   (input valid, input product_bcd, input input_error,
                  output ready);

endinterface

// ===== rtl/core/bdm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// BCD multiplier configuration channel
// Valid/ready write channel for the digit count register.
// ----------------------------------------------------------------------------
interface bdm_cfg_if import bdm_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [CfgWidth-1:0] digits_in_use;

  modport source (output valid, output digits_in_use, input ready);
  modport sink   (input valid, input digits_in_use, output ready);

endinterface

// ===== rtl/core/bdm_column_sum.sv =====
// ----------------------------------------------------------------------------
// BCD multiplier column sums
// Digit-by-digit products summed along each anti-diagonal (binary sums).
// ----------------------------------------------------------------------------
module bdm_column_sum import bdm_pkg::*; (
  input  logic [OperandWidth-1:0] multiplicand_i,
  input  logic [OperandWidth-1:0] multiplier_i,
  output col_vec_t                col_o
);

  logic [2*DigitWidth-1:0] dprod [MaxDigits][MaxDigits];

  always_comb begin
    for (int i = 0; i < MaxDigits; i++) begin
      for (int j = 0; j < MaxDigits; j++) begin
        dprod[i][j] = {{DigitWidth{1'b0}}, multiplicand_i[DigitWidth*i +: DigitWidth]} *
                      {{DigitWidth{1'b0}}, multiplier_i[DigitWidth*j +: DigitWidth]};
      end
    end
  end

  always_comb begin
    col_o = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      for (int j = 0; j < MaxDigits; j++) begin
        col_o[i+j] = col_o[i+j] + ColWidth'(dprod[i][j]);
      end
    end
  end

endmodule

// ===== rtl/core/bdm_carry_resolve.sv =====
// ----------------------------------------------------------------------------
// BCD multiplier carry resolve
// Final decimal add: digits of 0..11 in, carries by parallel prefix, BCD out.
// ----------------------------------------------------------------------------
module bdm_carry_resolve import bdm_pkg::*; (
  input  digit_vec_t              digit_i,
  output logic [ProductWidth-1:0] bcd_o
);

  localparam int Levels = $clog2(ProductDigits);

  logic [ProductDigits-1:0] gen;
  logic [ProductDigits-1:0] prop;
  logic [ProductDigits-1:0] cin;
  logic [DigitWidth:0]      sum [ProductDigits];

  always_comb begin
    for (int k = 0; k < ProductDigits; k++) begin
      gen[k]  = digit_i[k] >= DigitWidth'(10);
      prop[k] = digit_i[k] == DigitWidth'(9);
    end
    // inclusive prefix; descending k reads the previous level's lower terms
    for (int l = 0; l < Levels; l++) begin
      for (int k = ProductDigits - 1; k >= (1 << l); k--) begin
        gen[k]  = gen[k] | (prop[k] & gen[k-(1<<l)]);
        prop[k] = prop[k] & prop[k-(1<<l)];
      end
    end
    cin = {gen[ProductDigits-2:0], 1'b0};
  end

  always_comb begin
    for (int k = 0; k < ProductDigits; k++) begin
      sum[k] = {1'b0, digit_i[k]} + {{DigitWidth{1'b0}}, cin[k]};
      if (sum[k] >= (DigitWidth+1)'(10)) begin
        bcd_o[DigitWidth*k +: DigitWidth] = DigitWidth'(sum[k] - (DigitWidth+1)'(10));
      end else begin
        bcd_o[DigitWidth*k +: DigitWidth] = sum[k][DigitWidth-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/bcd_digit_multiplier.sv =====
// ----------------------------------------------------------------------------
// BCD digit multiplier
// Schoolbook packed-BCD multiplier, four register stages, one pair per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  operand_i   in   valid/ready    multiplicand_bcd[31:0], multiplier_bcd[31:0]
//  product_o   out  valid/ready    product_bcd[63:0], input_error
//  cfg_i       in   valid/ready    digits_in_use[3:0] (always ready)
//
//  One transaction per cycle while the product channel is not stalled.
//  Stages: operand register, column sums, digit split, carry resolve/output.
//  Reset empties the pipeline and sets digits_in_use to 8.
//  Ready propagates back through the stage valids, so bubbles are squeezed
//  out and a stalled output still lets earlier stages fill.
// ----------------------------------------------------------------------------
module bcd_digit_multiplier import bdm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  bdm_cfg_if.sink       cfg_i,
  bdm_operand_if.sink   operand_i,
  bdm_product_if.source product_o
);

  logic [CfgWidth-1:0]     digits_q;
  logic [CfgWidth-1:0]     n_eff;

  logic                    va_q, vb_q, vc_q, vo_q;
  logic                    en_a, en_b, en_c, en_o;

  logic [OperandWidth-1:0] a_q, b_q;
  logic                    err_b_d, err_b_q, err_c_q, err_o_q;
  col_vec_t                col_d, col_q;
  digit_vec_t              dig_d, dig_q;
  logic [ProductWidth-1:0] resolved;
  logic [ProductWidth-1:0] product_q;

  logic [7:0]              q1 [ProductDigits];
  logic [18:0]             q1_mul [ProductDigits];
  logic [11:0]             h_mul [ProductDigits];
  logic [ColWidth-1:0]     u_full [ProductDigits];
  bcd_digit_t              u, t, h;
  logic [7:0]              t_full [ProductDigits];
  logic [4:0]              s [ProductDigits];
  logic [1:0]              q [ProductDigits];
  bcd_digit_t              r [ProductDigits];
  bcd_digit_t              u_a [ProductDigits];
  bcd_digit_t              t_a [ProductDigits];
  bcd_digit_t              h_a [ProductDigits];

  logic                    col_ok, dig_ok;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= CfgDigitsReset;
    end else if (cfg_i.valid) begin
      digits_q <= cfg_i.digits_in_use;
    end
  end

  always_comb begin
    if (digits_q == '0) begin
      n_eff = CfgWidth'(1);
    end else if (digits_q > CfgWidth'(MaxDigits)) begin
      n_eff = CfgWidth'(MaxDigits);
    end else begin
      n_eff = digits_q;
    end
  end

  // pipeline flow control
  assign en_o = !vo_q || product_o.ready;
  assign en_c = !vc_q || en_o;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign operand_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_a) va_q <= operand_i.valid;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_o) vo_q <= vc_q;
    end
  end

  // stage A: operand register
  always_ff @(posedge clk_i) begin
    if (en_a && operand_i.valid) begin
      a_q <= operand_i.multiplicand_bcd;
      b_q <= operand_i.multiplier_bcd;
    end
  end

  // stage A -> B: malformed operand check and column sums
  always_comb begin
    err_b_d = 1'b0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (CfgWidth'(i) < n_eff) begin
        err_b_d = err_b_d || (a_q[DigitWidth*i +: DigitWidth] > DigitWidth'(9))
                          || (b_q[DigitWidth*i +: DigitWidth] > DigitWidth'(9));
      end else begin
        err_b_d = err_b_d || (a_q[DigitWidth*i +: DigitWidth] != '0)
                          || (b_q[DigitWidth*i +: DigitWidth] != '0);
      end
    end
  end

  bdm_column_sum u_column_sum (
    .multiplicand_i (a_q),
    .multiplier_i   (b_q),
    .col_o          (col_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      col_q   <= col_d;
      err_b_q <= err_b_d;
    end
  end

  // stage B -> C: split each column into decimal digits, fold to one addend
  always_comb begin
    u = '0;
    t = '0;
    h = '0;
    for (int k = 0; k < ProductDigits; k++) begin
      q1_mul[k] = 19'(col_q[k]) * 19'd205;
      q1[k]     = q1_mul[k][18:11];
      u_full[k] = col_q[k] - ColWidth'({q1[k], 3'b000}) - ColWidth'({q1[k], 1'b0});
      h_mul[k]  = 12'(q1[k]) * 12'd13;
      t_full[k] = q1[k] - {1'b0, h_mul[k][10:7], 3'b000}
                        - {3'b000, h_mul[k][10:7], 1'b0};
      u_a[k]    = u_full[k][DigitWidth-1:0];
      t_a[k]    = t_full[k][DigitWidth-1:0];
      h_a[k]    = h_mul[k][10:7];
    end
    for (int k = 0; k < ProductDigits; k++) begin
      u = u_a[k];
      t = (k >= 1) ? t_a[(k >= 1) ? k - 1 : 0] : '0;
      h = (k >= 2) ? h_a[(k >= 2) ? k - 2 : 0] : '0;
      s[k] = 5'(u) + 5'(t) + 5'(h);
      if (s[k] >= 5'd20) begin
        q[k] = 2'd2;
        r[k] = DigitWidth'(s[k] - 5'd20);
      end else if (s[k] >= 5'd10) begin
        q[k] = 2'd1;
        r[k] = DigitWidth'(s[k] - 5'd10);
      end else begin
        q[k] = 2'd0;
        r[k] = s[k][DigitWidth-1:0];
      end
    end
    for (int k = 0; k < ProductDigits; k++) begin
      dig_d[k] = r[k] + ((k >= 1) ? DigitWidth'(q[(k >= 1) ? k - 1 : 0]) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      dig_q   <= dig_d;
      err_c_q <= err_b_q;
    end
  end

  // stage C -> output: carry resolve
  bdm_carry_resolve u_carry_resolve (
    .digit_i (dig_q),
    .bcd_o   (resolved)
  );

  always_ff @(posedge clk_i) begin
    if (en_o && vc_q) begin
      product_q <= err_c_q ? '0 : resolved;
      err_o_q   <= err_c_q;
    end
  end

  assign product_o.valid       = vo_q;
  assign product_o.product_bcd = product_q;
  assign product_o.input_error = err_o_q;

  // checks on intermediate ranges
  always_comb begin
    col_ok = 1'b1;
    dig_ok = 1'b1;
    for (int k = 0; k < ProductDigits; k++) begin
      col_ok = col_ok && (col_q[k] <= ColMaxValid);
      dig_ok = dig_ok && (dig_q[k] <= DigitMaxSum);
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !err_b_q |-> col_ok)
    else $error("column sum out of range for a well-formed transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q && !err_c_q |-> dig_ok)
    else $error("folded digit above eleven for a well-formed transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q && !en_o |=> vc_q && $stable(dig_q) && $stable(err_c_q))
    else $error("digit stage lost or changed a stalled transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && err_o_q |-> product_q == '0)
    else $error("nonzero product flagged with input error");
`endif

endmodule
